// ===== rtl/nptt_pkg.sv =====
// ----------------------------------------------------------------------------
// nptt_pkg
// shared types, constants and codes of the port translation table
// ----------------------------------------------------------------------------
package nptt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = 6;

  // item kinds
  localparam logic [1:0] KIND_OUT  = 2'd0;
  localparam logic [1:0] KIND_IN   = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // result codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_EVICT    = 3'd2;
  localparam logic [2:0] ST_FW_DROP  = 3'd3;
  localparam logic [2:0] ST_REV_HIT  = 3'd4;
  localparam logic [2:0] ST_REV_MISS = 3'd5;
  localparam logic [2:0] ST_TICK     = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_PORT_BASE = 2'd0;
  localparam logic [1:0] REG_TCP_TTL   = 2'd1;
  localparam logic [1:0] REG_UDP_TTL   = 2'd2;
  localparam logic [1:0] REG_ICMP_TTL  = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic        fw_allow;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [7:0]  proto;
    logic [15:0] xlat_port;
  } qry_t;

  typedef struct packed {
    logic [31:0] tcp;
    logic [31:0] udp;
    logic [31:0] icmp;
  } ttl_t;

  typedef struct packed {
    logic             we;
    logic             full;
    logic [IDX_W-1:0] idx;
  } wr_t;

  typedef struct packed {
    logic             valid;
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic [15:0]      hit_wan;
    logic [31:0]      hit_lan_addr;
    logic [15:0]      hit_host_port;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             old_found;
    logic [31:0]      old_age;
    logic [IDX_W-1:0] old_idx;
    logic [CNT_W-1:0] cnt;
  } tok_t;

endpackage

// ===== rtl/nat_port_translation_table_unit.sv =====
// ----------------------------------------------------------------------------
// nat_port_translation_table_unit
// port address translation table with lru eviction, built as a cell chain
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one transaction per item; in_tuser carries the item kind
//           (outbound map, inbound reverse lookup, expiry tick)
//   out_* : one result transaction per item; out_tuser carries the status
//   cfg_* : plain register writes (port base and the three ttl values);
//           the user issues them only while the block is idle, the block itself does not enforce it
//   every item launches a scan token that walks the chain of entry cells,
//   one cell per cycle; each cell folds its entry into the token (first
//   match, first free slot, oldest entry, active count) and ticks expire
//   entries as the token passes. a catch register takes the finished token;
//   the commit state then writes or refreshes the chosen entry and loads
//   the output register. no new item is taken until that commit is done,
//   so each item waits for the last token to leave the whole cell chain.
//   the output register parts the two sides: the next item is accepted
//   while a result still waits; a stalled receiver holds the commit of the
//   following item until the output register frees up.
//   reset clears the state machine and the launch, cell, entry and output
//   flags and loads the config defaults; entries need no clearing pass.
// ----------------------------------------------------------------------------
module nat_port_translation_table_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] now_ms, [32] fw_allow, [64:33] src_addr, [80:65] src_port,
  // [112:81] dest_addr, [128:113] dest_port, [136:129] proto,
  // [152:137] wan port to look up, rest zero
  input  logic [159:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] mapped_port, [47:16] lan_addr, [63:48] lan side port,
  // [69:64] number of live entries, rest zero
  output logic [71:0]  out_tdata,
  // [2:0] status
  output logic [2:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import nptt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] port_base_r;
  ttl_t        ttl_r;
  qry_t        qry_r;
  tok_t        launch_r;
  tok_t        res_r;
  tok_t        tok [TABLE_ENTRIES+1];
  wr_t         wr;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_mport_r;
  logic [31:0] out_laddr_r;
  logic [15:0] out_lport_r;
  logic [5:0]  out_cnt_r;

  logic [2:0]  c_status;
  logic [15:0] c_mport;
  logic [31:0] c_laddr;
  logic [15:0] c_lport;
  logic [5:0]  c_cnt;
  logic        in_acc, out_free, commit;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign commit    = (state_r == S_COMMIT) && out_free;

  // the chain of entry cells
  assign tok[0] = launch_r;
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    nptt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .qry       (qry_r),
      .ttl       (ttl_r),
      .port_base (port_base_r),
      .wr        (wr),
      .tok_in    (tok[g]),
      .tok_out   (tok[g+1])
    );
  end

  // commit decision from the finished token
  always_comb begin
    c_status = ST_TICK;
    c_mport  = 16'd0;
    c_laddr  = 32'd0;
    c_lport  = 16'd0;
    c_cnt    = res_r.cnt;
    wr.we    = 1'b0;
    wr.full  = 1'b0;
    wr.idx   = res_r.hit_idx;
    if (qry_r.kind == KIND_OUT) begin
      if (!qry_r.fw_allow) begin
        c_status = ST_FW_DROP;
      end else if (res_r.hit_found) begin
        c_status = ST_HIT;
        c_mport  = res_r.hit_wan;
        wr.we    = commit;
      end else begin
        wr.we   = commit;
        wr.full = 1'b1;
        if (res_r.free_found) begin
          c_status = ST_NEW;
          wr.idx   = res_r.free_idx;
          c_cnt    = res_r.cnt + 6'd1;
        end else begin
          c_status = ST_EVICT;
          wr.idx   = res_r.old_idx;
        end
        c_mport = port_base_r + 16'(wr.idx);
      end
    end else if (qry_r.kind == KIND_IN) begin
      if (res_r.hit_found) begin
        c_status = ST_REV_HIT;
        c_laddr  = res_r.hit_lan_addr;
        c_lport  = res_r.hit_host_port;
        wr.we    = commit;
      end else begin
        c_status = ST_REV_MISS;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_SCAN;
      S_SCAN:   if (tok[TABLE_ENTRIES].valid) state_nxt = S_COMMIT;
      S_COMMIT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
      port_base_r    <= 16'd49152;
      ttl_r.tcp      <= 32'd300000;
      ttl_r.udp      <= 32'd60000;
      ttl_r.icmp     <= 32'd30000;
    end else begin
      state_r        <= state_nxt;
      launch_r.valid <= in_acc;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PORT_BASE: port_base_r <= cfg_wdata[15:0];
          REG_TCP_TTL:   ttl_r.tcp   <= cfg_wdata;
          REG_UDP_TTL:   ttl_r.udp   <= cfg_wdata;
          REG_ICMP_TTL:  ttl_r.icmp  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qry_r.kind      <= in_tuser;
      qry_r.now_ms    <= in_tdata[31:0];
      qry_r.fw_allow  <= in_tdata[32];
      qry_r.src_addr  <= in_tdata[64:33];
      qry_r.src_port  <= in_tdata[80:65];
      qry_r.dest_addr <= in_tdata[112:81];
      qry_r.dest_port <= in_tdata[128:113];
      qry_r.proto     <= in_tdata[136:129];
      qry_r.xlat_port <= in_tdata[152:137];
    end
    // empty token enters the first cell
    launch_r.hit_found     <= 1'b0;
    launch_r.hit_idx       <= '0;
    launch_r.hit_wan       <= 16'd0;
    launch_r.hit_lan_addr  <= 32'd0;
    launch_r.hit_host_port <= 16'd0;
    launch_r.free_found    <= 1'b0;
    launch_r.free_idx      <= '0;
    launch_r.old_found     <= 1'b0;
    launch_r.old_age       <= 32'd0;
    launch_r.old_idx       <= '0;
    launch_r.cnt           <= '0;
    // catch the token as it leaves the last cell
    if (tok[TABLE_ENTRIES].valid) begin
      res_r <= tok[TABLE_ENTRIES];
    end
    if (commit) begin
      out_status_r <= c_status;
      out_mport_r  <= c_mport;
      out_laddr_r  <= c_laddr;
      out_lport_r  <= c_lport;
      out_cnt_r    <= c_cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_lport_r, out_laddr_r, out_mport_r};

endmodule

// ===== rtl/nptt_cell.sv =====
// ----------------------------------------------------------------------------
// nptt_cell
// one table entry; updates the passing scan token and registers it onward
// ----------------------------------------------------------------------------
module nptt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [nptt_pkg::IDX_W-1:0] cell_idx,
  input  nptt_pkg::qry_t            qry,
  input  nptt_pkg::ttl_t            ttl,
  input  logic [15:0]               port_base,
  input  nptt_pkg::wr_t             wr,
  input  nptt_pkg::tok_t            tok_in,
  output nptt_pkg::tok_t            tok_out
);
  import nptt_pkg::*;

  logic        active_r;
  logic [31:0] lan_addr_r;
  logic [15:0] host_port_r;
  logic [31:0] dest_addr_r;
  logic [15:0] dest_port_r;
  logic [7:0]  proto_r;
  logic [15:0] wan_port_r;
  logic [31:0] last_seen_r;
  tok_t        tok_r;
  tok_t        tok_nxt;

  logic [31:0] age;
  logic [31:0] life;
  logic        is_out, is_in, expire, out_match, in_match, sel;

  always_comb begin
    age    = qry.now_ms - last_seen_r;
    is_out = (qry.kind == KIND_OUT);
    is_in  = (qry.kind == KIND_IN);
    if (proto_r == PROTO_TCP) begin
      life = ttl.tcp;
    end else if (proto_r == PROTO_ICMP) begin
      life = ttl.icmp;
    end else begin
      life = ttl.udp;
    end
    expire = tok_in.valid && !is_out && !is_in && active_r && (age > life);
    out_match = active_r && (lan_addr_r == qry.src_addr) && (host_port_r == qry.src_port)
                && (dest_addr_r == qry.dest_addr) && (dest_port_r == qry.dest_port)
                && (proto_r == qry.proto);
    in_match  = active_r && (wan_port_r == qry.xlat_port) && (proto_r == qry.proto);

    tok_nxt = tok_in;
    if (is_out) begin
      if (!tok_in.hit_found && out_match) begin
        tok_nxt.hit_found = 1'b1;
        tok_nxt.hit_idx   = cell_idx;
        tok_nxt.hit_wan   = wan_port_r;
      end
      if (!tok_in.free_found && !active_r) begin
        tok_nxt.free_found = 1'b1;
        tok_nxt.free_idx   = cell_idx;
      end
      if (active_r && (!tok_in.old_found || age > tok_in.old_age)) begin
        tok_nxt.old_found = 1'b1;
        tok_nxt.old_age   = age;
        tok_nxt.old_idx   = cell_idx;
      end
    end else if (is_in) begin
      if (!tok_in.hit_found && in_match) begin
        tok_nxt.hit_found     = 1'b1;
        tok_nxt.hit_idx       = cell_idx;
        tok_nxt.hit_lan_addr  = lan_addr_r;
        tok_nxt.hit_host_port = host_port_r;
      end
    end
    tok_nxt.cnt = tok_in.cnt + CNT_W'(active_r && !expire);
    sel = wr.we && (wr.idx == cell_idx);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
      if (sel && wr.full) begin
        active_r <= 1'b1;
      end else if (expire) begin
        active_r <= 1'b0;
      end
    end
  end

  // entry payload and token payload
  always_ff @(posedge clk) begin
    tok_r.hit_found     <= tok_nxt.hit_found;
    tok_r.hit_idx       <= tok_nxt.hit_idx;
    tok_r.hit_wan       <= tok_nxt.hit_wan;
    tok_r.hit_lan_addr  <= tok_nxt.hit_lan_addr;
    tok_r.hit_host_port <= tok_nxt.hit_host_port;
    tok_r.free_found    <= tok_nxt.free_found;
    tok_r.free_idx      <= tok_nxt.free_idx;
    tok_r.old_found     <= tok_nxt.old_found;
    tok_r.old_age       <= tok_nxt.old_age;
    tok_r.old_idx       <= tok_nxt.old_idx;
    tok_r.cnt           <= tok_nxt.cnt;
    if (sel) begin
      last_seen_r <= qry.now_ms;
      if (wr.full) begin
        lan_addr_r  <= qry.src_addr;
        host_port_r <= qry.src_port;
        dest_addr_r <= qry.dest_addr;
        dest_port_r <= qry.dest_port;
        proto_r     <= qry.proto;
        wan_port_r  <= port_base + 16'(cell_idx);
      end
    end
  end

  assign tok_out = tok_r;

endmodule
